// ===== design/bhm_pkg.sv =====
// Package for the binned height map: operation codes, register map,
// empty-bin codes and the payload types of the input and result channels.
// Depends on nothing; bhm_bin_index and binned_height_map_max_min use it.
package bhm_pkg;

    localparam int DEF_MAX_BINS_X = 64;
    localparam int DEF_MAX_BINS_Y = 64;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int BINS_W = 7;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_SCALE_X  = 3'd2;
    localparam logic [2:0] REG_SCALE_Y  = 3'd3;
    localparam logic [2:0] REG_BINS_X   = 3'd4;
    localparam logic [2:0] REG_BINS_Y   = 3'd5;

    localparam logic [31:0] EMPTY_TOP    = 32'h8000_0000;
    localparam logic [31:0] EMPTY_BOTTOM = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [5:0]         read_bin_x;
        logic [5:0]         read_bin_y;
    } t_bhm_in;

    typedef struct packed {
        logic signed [31:0] top_height;
        logic signed [31:0] bottom_height;
    } t_bhm_out;

    typedef struct packed {
        logic signed [31:0] origin;
        logic [31:0]        scale;
    } t_axis_cfg;

endpackage

// ===== design/bhm_stream_if.sv =====
// Valid/ready stream interface used for the input and result channels.
// The payload type is a parameter; the block uses the types of bhm_pkg.
interface bhm_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/bhm_bin_index.sv =====
// Maps one coordinate to a bin index along one axis: subtract the origin,
// multiply by the scale, keep the integer part and clamp to the bins in use.
// Two register stages; depends on bhm_pkg.
module bhm_bin_index #(
    parameter int MAX_BINS = bhm_pkg::DEF_MAX_BINS_X,
    localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1,
    localparam int NW = $clog2(MAX_BINS + 1)
) (
    input  logic                      i_clk,
    input  logic signed [31:0]        i_pos,
    input  bhm_pkg::t_axis_cfg        i_cfg,
    input  logic [NW-1:0]             i_count,
    output logic [BW-1:0]             o_index
);
    import bhm_pkg::*;

    logic [32:0] w_diff;
    logic [63:0] w_prod;
    logic [31:0] r_diff;
    logic        r_neg;
    logic [31:0] r_prod_hi;
    logic        r_neg_d;

    assign w_diff = {i_pos[31], i_pos} - {i_cfg.origin[31], i_cfg.origin};
    assign w_prod = 64'(r_diff) * 64'(i_cfg.scale);

    always_ff @(posedge i_clk) begin
        r_diff    <= w_diff[31:0];
        r_neg     <= w_diff[32];
        r_prod_hi <= w_prod[63:32];
        r_neg_d   <= r_neg;
    end

    always_comb begin
        if (r_neg_d) begin
            o_index = '0;
        end else if (r_prod_hi >= 32'(i_count)) begin
            o_index = BW'(i_count - NW'(1));
        end else begin
            o_index = BW'(r_prod_hi);
        end
    end

endmodule

// ===== design/binned_height_map_max_min.sv =====
// Binned max/min height map. Input transfers on i_in carry an operation:
// clear all bins, add a particle (x, y pick a bin, z updates its maximum
// and minimum) or read one bin. Only a read produces a result transfer on
// o_out, holding the bin's top and bottom heights.
// The user must write registers through the APB port only while the block
// is idle; the block itself does not enforce it. An add or read steps
// through ST_SUB, ST_MUL (bin arithmetic), ST_ADDR (memory read) and ST_UPD
// (write back for an add, result load for a read) before the next input
// can be taken. A clear sweeps the state memory one entry per cycle; after
// reset the same sweep runs before i_in.ready rises.
// The result sits in an output register; a read waits in its last step
// while that register still holds an untaken result, and other operations
// go on regardless of the receiver.
// Depends on bhm_pkg, bhm_stream_if and bhm_bin_index.
module binned_height_map_max_min #(
    parameter int MAX_BINS_X = bhm_pkg::DEF_MAX_BINS_X,
    parameter int MAX_BINS_Y = bhm_pkg::DEF_MAX_BINS_Y
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bhm_stream_if.sink                  i_in,
    bhm_stream_if.source                o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bhm_pkg::APB_AW-1:0]  paddr,
    input  logic [bhm_pkg::APB_DW-1:0]  pwdata,
    output logic [bhm_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import bhm_pkg::*;

    localparam int DEPTH = MAX_BINS_X * MAX_BINS_Y;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BXW   = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
    localparam int BYW   = (MAX_BINS_Y > 1) ? $clog2(MAX_BINS_Y) : 1;
    localparam int NXW   = $clog2(MAX_BINS_X + 1);
    localparam int NYW   = $clog2(MAX_BINS_Y + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SUB   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_ADDR  = 3'd4;
    localparam logic [2:0] ST_UPD   = 3'd5;

    logic [31:0]        r_origin_x, r_origin_y, r_scale_x, r_scale_y;
    logic [BINS_W-1:0]  r_bins_x, r_bins_y;
    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic [AW-1:0]      r_addr;
    t_bhm_in            r_item;
    logic               r_out_valid, n_out_valid;
    t_bhm_out           r_out;
    logic [63:0]        r_mem_q;
    logic [63:0]        mem [DEPTH];

    t_axis_cfg          w_cfg_x, w_cfg_y;
    logic [NXW-1:0]     w_nx;
    logic [NYW-1:0]     w_ny;
    logic [BXW-1:0]     w_px, w_rbx, w_bx;
    logic [BYW-1:0]     w_py, w_rby, w_by;
    logic [AW-1:0]      w_rd_addr;
    logic               w_accept, w_cfg_wr, w_out_load;
    logic               w_mem_we, w_mem_re;
    logic [AW-1:0]      w_wr_addr;
    logic [63:0]        w_wr_data;
    logic [31:0]        w_top, w_bot, w_top_new, w_bot_new;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_scale_x  <= 32'd65536;
            r_scale_y  <= 32'd65536;
            r_bins_x   <= BINS_W'(64);
            r_bins_y   <= BINS_W'(64);
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                REG_ORIGIN_X: r_origin_x <= pwdata;
                REG_ORIGIN_Y: r_origin_y <= pwdata;
                REG_SCALE_X:  r_scale_x  <= pwdata;
                REG_SCALE_Y:  r_scale_y  <= pwdata;
                REG_BINS_X:   r_bins_x   <= pwdata[BINS_W-1:0];
                REG_BINS_Y:   r_bins_y   <= pwdata[BINS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_ORIGIN_X: prdata = r_origin_x;
            REG_ORIGIN_Y: prdata = r_origin_y;
            REG_SCALE_X:  prdata = r_scale_x;
            REG_SCALE_Y:  prdata = r_scale_y;
            REG_BINS_X:   prdata = 32'(r_bins_x);
            REG_BINS_Y:   prdata = 32'(r_bins_y);
            default:      prdata = '0;
        endcase
    end

    assign w_nx = (r_bins_x == '0) ? NXW'(1) :
                  ((32'(r_bins_x) > MAX_BINS_X) ? NXW'(MAX_BINS_X) : NXW'(r_bins_x));
    assign w_ny = (r_bins_y == '0) ? NYW'(1) :
                  ((32'(r_bins_y) > MAX_BINS_Y) ? NYW'(MAX_BINS_Y) : NYW'(r_bins_y));

    assign w_cfg_x = '{origin: r_origin_x, scale: r_scale_x};
    assign w_cfg_y = '{origin: r_origin_y, scale: r_scale_y};

    bhm_bin_index #(.MAX_BINS(MAX_BINS_X)) u_index_x (
        .i_clk   (i_clk),
        .i_pos   (r_item.pos_x),
        .i_cfg   (w_cfg_x),
        .i_count (w_nx),
        .o_index (w_px)
    );

    bhm_bin_index #(.MAX_BINS(MAX_BINS_Y)) u_index_y (
        .i_clk   (i_clk),
        .i_pos   (r_item.pos_y),
        .i_cfg   (w_cfg_y),
        .i_count (w_ny),
        .o_index (w_py)
    );

    assign w_rbx = (32'(r_item.read_bin_x) >= 32'(w_nx)) ? BXW'(w_nx - NXW'(1)) :
                   BXW'(r_item.read_bin_x);
    assign w_rby = (32'(r_item.read_bin_y) >= 32'(w_ny)) ? BYW'(w_ny - NYW'(1)) :
                   BYW'(r_item.read_bin_y);
    assign w_bx  = (r_item.operation == OP_READ) ? w_rbx : w_px;
    assign w_by  = (r_item.operation == OP_READ) ? w_rby : w_py;
    assign w_rd_addr = AW'(w_bx) * AW'(MAX_BINS_Y) + AW'(w_by);

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_top     = r_mem_q[63:32];
    assign w_bot     = r_mem_q[31:0];
    assign w_top_new = ($signed(r_item.pos_z) > $signed(w_top)) ? r_item.pos_z : w_top;
    assign w_bot_new = ($signed(r_item.pos_z) < $signed(w_bot)) ? r_item.pos_z : w_bot;

    assign w_out_load = (r_state == ST_UPD) && (r_item.operation == OP_READ) &&
                        (!r_out_valid || o_out.ready);
    assign w_mem_re   = (r_state == ST_ADDR);

    always_comb begin
        w_mem_we  = 1'b0;
        w_wr_addr = r_addr;
        w_wr_data = {w_top_new, w_bot_new};
        if (r_state == ST_CLEAR) begin
            w_mem_we  = 1'b1;
            w_wr_addr = r_cnt;
            w_wr_data = {EMPTY_TOP, EMPTY_BOTTOM};
        end else if (r_state == ST_UPD && r_item.operation == OP_ADD) begin
            w_mem_we  = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_CLEAR: begin
                if (r_cnt == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in.data.operation)
                        OP_CLEAR: n_state = ST_CLEAR;
                        OP_ADD:   n_state = ST_SUB;
                        OP_READ:  n_state = ST_SUB;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SUB:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_ADDR;
            ST_ADDR: n_state = ST_UPD;
            ST_UPD: begin
                if (r_item.operation != OP_READ || w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in.data;
        end
        if (w_mem_re) begin
            r_addr <= w_rd_addr;
        end
        if (w_out_load) begin
            r_out <= '{top_height: w_top, bottom_height: w_bot};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_mem_re) begin
            r_mem_q <= mem[w_rd_addr];
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_clear_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in.data.operation == OP_CLEAR |=> r_state == ST_CLEAR && r_cnt == '0)
        else $error("clear transfer did not start the sweep");

    a_sweep_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_CLEAR |-> r_cnt == '0)
        else $error("sweep counter left nonzero outside the sweep");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_we && w_mem_re))
        else $error("memory read and write issued in the same cycle");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_UPD && r_item.operation == OP_READ && !r_out_valid |=> r_out_valid)
        else $error("read did not load the result register");

endmodule
